@@ hw/rtl/poly_voice_allocator_core_defines.svh @@
// Assertion macros for the voice allocator core.
// Used by the top level; expects aclk and aresetn in scope.
`ifndef POLY_VOICE_ALLOCATOR_CORE_DEFINES_SVH
`define POLY_VOICE_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PVA_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pva: assertion failed");

// next-cycle implication, checked outside reset
`define PVA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pva: assertion failed");

`endif

@@ hw/rtl/pva_pkg.sv @@
// Shared types and constants for the voice allocator core.
// No dependencies; used by pva_ctrl, pva_dpath and the top level.
package pva_pkg;

    localparam int VOICES      = 8;
    localparam int VIDX_W      = 3;
    localparam int LEN_W       = 4;
    localparam int NOTE_W      = 7;
    localparam int VEL_W       = 7;
    localparam int STATUS_W    = 2;
    localparam int POLICY_W    = 2;
    localparam int CFG_W       = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int S_TDATA_W   = 16;
    localparam int S_TUSER_W   = 1;
    localparam int M_TDATA_W   = 24;
    localparam int M_TUSER_W   = 3;
    localparam int M_PAD_W     = M_TDATA_W - VIDX_W - NOTE_W - VEL_W;

    // opcodes
    localparam logic OP_NOTE_ON  = 1'b0;
    localparam logic OP_NOTE_OFF = 1'b1;

    // steal policies
    localparam logic [POLICY_W-1:0] POL_NONE   = 2'd0;
    localparam logic [POLICY_W-1:0] POL_OLDEST = 2'd1;
    localparam logic [POLICY_W-1:0] POL_LOWEST = 2'd2;

    // result status
    localparam logic [STATUS_W-1:0] ST_STARTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_STOPPED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_VOICE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_MATCH = 2'd3;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STEAL_POLICY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VOICE_COUNT  = 1'd1;

    typedef struct packed {
        logic load;         // latch the input beat
        logic pick_idle;    // take front idle voice
        logic pick_oldest;  // take front active voice
        logic start_scan;   // begin walk over the active queue
        logic scan_step;    // examine one active entry
        logic commit;       // update queues and load result
    } cmd_t;

    typedef struct packed {
        logic             op_off;
        logic             idle_avail;
        logic             act_avail;
        logic             steal_oldest;
        logic             steal_lowest;
        logic             scan_end;
        logic             hit;
        logic             out_free;
        logic [LEN_W-1:0] idle_len;
        logic [LEN_W-1:0] act_len;
    } sts_t;

endpackage

@@ hw/rtl/poly_voice_allocator_core.sv @@
// Polyphonic voice allocator with note stealing.
// Input: one beat per note event on s_*; config writes on cfg_*.
// Output: one result beat per event on m_*.
// Sequence: accept, choose, then for a note-off or lowest-note steal a scan
// of the active queue, one entry per cycle up to its end check, then commit.
// A note-off scan stops at the first matching entry.
// Throughput: one event at a time; the next event is accepted the cycle
// after the previous one commits.
// The result register holds a finished result while the next event is
// taken; if the receiver stalls, the following commit waits for it.
// Reset: policy none, pool of 8 voices idle in order, notes cleared.
// Writing voice_count refills the idle queue and empties the active one;
// configure only while no event is in flight.
// Depends on pva_pkg, pva_ctrl, pva_dpath and the defines header.
`include "poly_voice_allocator_core_defines.svh"

module poly_voice_allocator_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pva_pkg::S_TDATA_W-1:0]   s_tdata,   // note[6:0], velocity[13:7]
    input  logic [pva_pkg::S_TUSER_W-1:0]   s_tuser,   // opcode[0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pva_pkg::M_TDATA_W-1:0]   m_tdata,   // voice[2:0], note_out[9:3],
                                                       // velocity_out[16:10]
    output logic [pva_pkg::M_TUSER_W-1:0]   m_tuser,   // status[1:0], gate[2]
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pva_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pva_pkg::CFG_W-1:0]       cfg_data
);

    pva_pkg::cmd_t cmd;
    pva_pkg::sts_t sts;
    logic [pva_pkg::LEN_W:0] pool_used;

    assign cfg_ready = 1'b1;
    assign pool_used = {1'b0, sts.idle_len} + {1'b0, sts.act_len};

    pva_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pva_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

    // one event in flight at a time
    `PVA_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)

    // gate is raised exactly on a started result
    `PVA_ASSERT(a_gate_started, m_tvalid, m_tuser[2] == (m_tuser[1:0] == pva_pkg::ST_STARTED))

    // idle and active queues together never hold more than the pool
    `PVA_ASSERT(a_pool_bound, 1'b1, pool_used <= (pva_pkg::LEN_W + 1)'(pva_pkg::VOICES))

endmodule

@@ hw/rtl/pva_ctrl.sv @@
// Sequencer for the voice allocator: accept, choose, scan, commit.
// Depends on pva_pkg for cmd_t and sts_t.
module pva_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  pva_pkg::sts_t sts,
    output pva_pkg::cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHOOSE,
        S_SCAN,
        S_COMMIT
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        ready_next = ready_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && ready_reg) begin
                    cmd.load   = 1'b1;
                    ready_next = 1'b0;
                    state_next = S_CHOOSE;
                end
            end
            S_CHOOSE: begin
                if (sts.op_off) begin
                    cmd.start_scan = 1'b1;
                    state_next     = S_SCAN;
                end else if (sts.idle_avail) begin
                    cmd.pick_idle = 1'b1;
                    state_next    = S_COMMIT;
                end else if (sts.steal_oldest && sts.act_avail) begin
                    cmd.pick_oldest = 1'b1;
                    state_next      = S_COMMIT;
                end else if (sts.steal_lowest) begin
                    cmd.start_scan = 1'b1;
                    state_next     = S_SCAN;
                end else begin
                    state_next = S_COMMIT;   // dropped note
                end
            end
            S_SCAN: begin
                if (sts.scan_end) begin
                    state_next = S_COMMIT;
                end else begin
                    cmd.scan_step = 1'b1;
                    // note-off stops at the first match
                    if (sts.hit) begin
                        state_next = S_COMMIT;
                    end
                end
            end
            S_COMMIT: begin
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    ready_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign s_tready = ready_reg;

endmodule

@@ hw/rtl/pva_dpath.sv @@
// Datapath for the voice allocator: voice queues, note table, scan
// registers, config registers and the result register. Uses pva_pkg.
module pva_dpath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [pva_pkg::S_TDATA_W-1:0]       s_tdata,
    input  logic [pva_pkg::S_TUSER_W-1:0]       s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [pva_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic [pva_pkg::M_TUSER_W-1:0]       m_tuser,
    input  logic                                cfg_valid,
    input  logic [pva_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pva_pkg::CFG_W-1:0]           cfg_data,
    input  pva_pkg::cmd_t                       cmd,
    output pva_pkg::sts_t                       sts
);

    typedef logic [pva_pkg::VIDX_W-1:0] vidx_t;
    typedef logic [pva_pkg::NOTE_W-1:0] note_t;
    typedef logic [pva_pkg::LEN_W-1:0]  len_t;

    typedef enum logic {
        SRC_IDLE,
        SRC_ACT
    } src_t;

    // queues and note table
    vidx_t idle_q_reg [pva_pkg::VOICES];
    vidx_t idle_q_next[pva_pkg::VOICES];
    vidx_t act_q_reg  [pva_pkg::VOICES];
    vidx_t act_q_next [pva_pkg::VOICES];
    note_t vnote_reg  [pva_pkg::VOICES];
    note_t vnote_next [pva_pkg::VOICES];
    len_t  idle_len_reg, idle_len_next;
    len_t  act_len_reg,  act_len_next;
    logic [pva_pkg::POLICY_W-1:0] policy_reg, policy_next;

    // current event and scan state
    logic                        op_reg,    op_next;
    note_t                       note_reg,  note_next;
    logic [pva_pkg::VEL_W-1:0]   vel_reg,   vel_next;
    len_t                        idx_reg,   idx_next;
    note_t                       low_reg,   low_next;
    vidx_t                       pos_reg,   pos_next;
    vidx_t                       vsel_reg,  vsel_next;
    logic                        found_reg, found_next;
    src_t                        src_reg,   src_next;

    // result register
    logic                           oval_reg,   oval_next;
    logic [pva_pkg::STATUS_W-1:0]   ostat_reg,  ostat_next;
    vidx_t                          ovoice_reg, ovoice_next;
    note_t                          onote_reg,  onote_next;
    logic [pva_pkg::VEL_W-1:0]      ovel_reg,   ovel_next;
    logic                           ogate_reg,  ogate_next;

    vidx_t cur_v;
    note_t cur_n;
    logic  out_free;

    assign cur_v    = act_q_reg[idx_reg[pva_pkg::VIDX_W-1:0]];
    assign cur_n    = vnote_reg[cur_v];
    assign out_free = !oval_reg || m_tready;

    always_comb begin
        sts.op_off       = (op_reg == pva_pkg::OP_NOTE_OFF);
        sts.idle_avail   = (idle_len_reg != '0);
        sts.act_avail    = (act_len_reg != '0);
        sts.steal_oldest = (policy_reg == pva_pkg::POL_OLDEST);
        sts.steal_lowest = (policy_reg == pva_pkg::POL_LOWEST);
        sts.scan_end     = (idx_reg == act_len_reg);
        sts.hit          = (op_reg == pva_pkg::OP_NOTE_OFF) && (cur_n == note_reg);
        sts.out_free     = out_free;
        sts.idle_len     = idle_len_reg;
        sts.act_len      = act_len_reg;
    end

    always_comb begin
        idle_q_next   = idle_q_reg;
        act_q_next    = act_q_reg;
        vnote_next    = vnote_reg;
        idle_len_next = idle_len_reg;
        act_len_next  = act_len_reg;
        policy_next   = policy_reg;
        op_next       = op_reg;
        note_next     = note_reg;
        vel_next      = vel_reg;
        idx_next      = idx_reg;
        low_next      = low_reg;
        pos_next      = pos_reg;
        vsel_next     = vsel_reg;
        found_next    = found_reg;
        src_next      = src_reg;
        oval_next     = oval_reg && !m_tready;
        ostat_next    = ostat_reg;
        ovoice_next   = ovoice_reg;
        onote_next    = onote_reg;
        ovel_next     = ovel_reg;
        ogate_next    = ogate_reg;

        if (cmd.load) begin
            op_next    = s_tuser[0];
            note_next  = s_tdata[pva_pkg::NOTE_W-1:0];
            vel_next   = s_tdata[pva_pkg::NOTE_W +: pva_pkg::VEL_W];
            found_next = 1'b0;
        end

        if (cmd.pick_idle) begin
            src_next   = SRC_IDLE;
            found_next = 1'b1;
            vsel_next  = idle_q_reg[0];
        end

        if (cmd.pick_oldest) begin
            src_next   = SRC_ACT;
            found_next = 1'b1;
            pos_next   = '0;
            vsel_next  = act_q_reg[0];
        end

        if (cmd.start_scan) begin
            src_next   = SRC_ACT;
            found_next = 1'b0;
            idx_next   = '0;
            low_next   = note_reg;
        end

        if (cmd.scan_step) begin
            idx_next = idx_reg + len_t'(1);
            if (op_reg == pva_pkg::OP_NOTE_OFF) begin
                if (cur_n == note_reg) begin
                    found_next = 1'b1;
                    pos_next   = idx_reg[pva_pkg::VIDX_W-1:0];
                    vsel_next  = cur_v;
                end
            end else if (cur_n < low_reg) begin
                // strictly lower keeps the earliest of equal lows
                low_next   = cur_n;
                found_next = 1'b1;
                pos_next   = idx_reg[pva_pkg::VIDX_W-1:0];
                vsel_next  = cur_v;
            end
        end

        if (cmd.commit) begin
            oval_next   = 1'b1;
            ovoice_next = '0;
            onote_next  = '0;
            ovel_next   = '0;
            ogate_next  = 1'b0;

            // take the chosen voice out of its queue
            if (found_reg) begin
                if (src_reg == SRC_IDLE) begin
                    for (int j = 0; j < pva_pkg::VOICES - 1; j++) begin
                        idle_q_next[j] = idle_q_reg[j+1];
                    end
                    idle_len_next = idle_len_reg - len_t'(1);
                end else begin
                    for (int j = 0; j < pva_pkg::VOICES - 1; j++) begin
                        if (vidx_t'(j) >= pos_reg) begin
                            act_q_next[j] = act_q_reg[j+1];
                        end
                    end
                    act_len_next = act_len_reg - len_t'(1);
                end
            end

            if (op_reg == pva_pkg::OP_NOTE_ON) begin
                if (found_reg && (act_len_next < len_t'(pva_pkg::VOICES))) begin
                    act_q_next[act_len_next[pva_pkg::VIDX_W-1:0]] = vsel_reg;
                    act_len_next          = act_len_next + len_t'(1);
                    vnote_next[vsel_reg]  = note_reg;
                    ostat_next            = pva_pkg::ST_STARTED;
                    ovoice_next           = vsel_reg;
                    onote_next            = note_reg;
                    ovel_next             = vel_reg;
                    ogate_next            = 1'b1;
                end else begin
                    ostat_next = pva_pkg::ST_NO_VOICE;
                end
            end else begin
                if (found_reg) begin
                    if (idle_len_reg < len_t'(pva_pkg::VOICES)) begin
                        idle_q_next[idle_len_reg[pva_pkg::VIDX_W-1:0]] = vsel_reg;
                        idle_len_next = idle_len_reg + len_t'(1);
                    end
                    ostat_next  = pva_pkg::ST_STOPPED;
                    ovoice_next = vsel_reg;
                    onote_next  = note_reg;
                end else begin
                    ostat_next = pva_pkg::ST_NO_MATCH;
                end
            end
        end

        if (cfg_valid) begin
            unique case (cfg_index)
                pva_pkg::REG_STEAL_POLICY: begin
                    policy_next = cfg_data[pva_pkg::POLICY_W-1:0];
                end
                pva_pkg::REG_VOICE_COUNT: begin
                    for (int j = 0; j < pva_pkg::VOICES; j++) begin
                        idle_q_next[j] = vidx_t'(j);
                    end
                    // oversized pool saturates
                    if (cfg_data > pva_pkg::CFG_W'(pva_pkg::VOICES)) begin
                        idle_len_next = len_t'(pva_pkg::VOICES);
                    end else begin
                        idle_len_next = len_t'(cfg_data);
                    end
                    act_len_next = '0;
                end
                default: begin
                    policy_next = policy_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < pva_pkg::VOICES; j++) begin
                idle_q_reg[j] <= vidx_t'(j);
                vnote_reg[j]  <= '0;
            end
            idle_len_reg <= len_t'(pva_pkg::VOICES);
            act_len_reg  <= '0;
            policy_reg   <= pva_pkg::POL_NONE;
            oval_reg     <= 1'b0;
            found_reg    <= 1'b0;
            src_reg      <= SRC_IDLE;
            idx_reg      <= '0;
        end else begin
            idle_q_reg   <= idle_q_next;
            vnote_reg    <= vnote_next;
            idle_len_reg <= idle_len_next;
            act_len_reg  <= act_len_next;
            policy_reg   <= policy_next;
            oval_reg     <= oval_next;
            found_reg    <= found_next;
            src_reg      <= src_next;
            idx_reg      <= idx_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        act_q_reg  <= act_q_next;
        op_reg     <= op_next;
        note_reg   <= note_next;
        vel_reg    <= vel_next;
        low_reg    <= low_next;
        pos_reg    <= pos_next;
        vsel_reg   <= vsel_next;
        ostat_reg  <= ostat_next;
        ovoice_reg <= ovoice_next;
        onote_reg  <= onote_next;
        ovel_reg   <= ovel_next;
        ogate_reg  <= ogate_next;
    end

    assign m_tvalid = oval_reg;
    assign m_tdata  = {{pva_pkg::M_PAD_W{1'b0}}, ovel_reg, onote_reg, ovoice_reg};
    assign m_tuser  = {ogate_reg, ostat_reg};

endmodule
